// File: rtl/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types, codes and reset values of the engine start/stop sequencer.
// ----------------------------------------------------------------------------
package ess_pkg;

    localparam int unsigned SPEED_W = 12;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] MODE_REMOTE = 2'd0;
    localparam logic [1:0] MODE_UPPER  = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;
    localparam logic [1:0] MODE_KEEP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRANK       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WAIT   = 2'd3;

    localparam logic [CFG_W-1:0] RST_RUN_SPEED  = 12'd500;
    localparam logic [CFG_W-1:0] RST_POWER_WAIT = 12'd1100;
    localparam logic [CFG_W-1:0] RST_CRANK      = 12'd250;
    localparam logic [CFG_W-1:0] RST_STOP_WAIT  = 12'd200;

    typedef enum logic [4:0] {
        SP_POWER_ON  = 5'b00001,
        SP_POWER_WT  = 5'b00010,
        SP_CRANK     = 5'b00100,
        SP_CRANK_WT  = 5'b01000,
        SP_RELEASE   = 5'b10000
    } t_start_phase;

    typedef enum logic [2:0] {
        TP_OFF   = 3'b001,
        TP_WAIT  = 3'b010,
        TP_CLEAR = 3'b100
    } t_stop_phase;

    typedef struct packed {
        logic               halt;
        logic [1:0]         control_mode;
        logic [1:0]         remote_cmd;
        logic [1:0]         upper_cmd;
        logic [SPEED_W-1:0] speed_rpm;
    } t_in;

    typedef struct packed {
        logic       start_relay;
        logic       power_relay;
        logic       throttle_zero;
        logic       speed_forced_zero;
        logic       engine_running;
        logic [1:0] held_order;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] run_speed;
        logic [CFG_W-1:0] power_wait_ticks;
        logic [CFG_W-1:0] crank_ticks;
        logic [CFG_W-1:0] stop_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         held_order;
        t_start_phase       start_phase;
        logic [COUNT_W-1:0] start_count;
        t_stop_phase        stop_phase;
        logic [COUNT_W-1:0] stop_count;
        logic               running;
        logic               start_relay;
        logic               power_relay;
    } t_state;

endpackage

// File: rtl/ess_cfg_regs.sv
// ----------------------------------------------------------------------------
// ess_cfg_regs
// Threshold and wait-limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ess_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ess_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ess_pkg::CFG_W-1:0]     i_cfg_data,
    output ess_pkg::t_cfg                 o_cfg
);
    import ess_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_speed        <= RST_RUN_SPEED;
            r_cfg.power_wait_ticks <= RST_POWER_WAIT;
            r_cfg.crank_ticks      <= RST_CRANK;
            r_cfg.stop_wait_ticks  <= RST_STOP_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN_SPEED:  r_cfg.run_speed        <= i_cfg_data;
                CFG_POWER_WAIT: r_cfg.power_wait_ticks <= i_cfg_data;
                CFG_CRANK:      r_cfg.crank_ticks      <= i_cfg_data;
                CFG_STOP_WAIT:  r_cfg.stop_wait_ticks  <= i_cfg_data;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/ess_tick.sv
// ----------------------------------------------------------------------------
// ess_tick
// One control tick: command select, order latch, start and stop sequences,
// running check. Produces the next state and the tick result.
// ----------------------------------------------------------------------------
module ess_tick (
    input  ess_pkg::t_in    i_item,
    input  ess_pkg::t_cfg   i_cfg,
    input  ess_pkg::t_state i_state,
    output ess_pkg::t_state o_state,
    output ess_pkg::t_out   o_result
);
    import ess_pkg::*;

    logic [COUNT_W:0]   start_inc;
    logic [COUNT_W:0]   stop_inc;
    logic [SPEED_W-1:0] eff_speed;
    logic               throttle;
    logic               forced;
    t_state             n_st;

    assign start_inc = {1'b0, i_state.start_count} + {{COUNT_W{1'b0}}, 1'b1};
    assign stop_inc  = {1'b0, i_state.stop_count} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_st     = i_state;
        throttle = 1'b0;
        forced   = 1'b0;

        if (i_item.halt) begin
            n_st.command = CMD_NONE;
        end else begin
            unique case (i_item.control_mode)
                MODE_REMOTE: n_st.command = i_item.remote_cmd;
                MODE_UPPER:  n_st.command = i_item.upper_cmd;
                MODE_MANUAL: n_st.command = CMD_NONE;
                MODE_KEEP:   n_st.command = i_state.command;
                default:     n_st.command = i_state.command;
            endcase
        end

        if (n_st.command == CMD_STOP) begin
            n_st.held_order = CMD_STOP;
        end else if (n_st.command == CMD_START && !i_state.running) begin
            n_st.held_order = CMD_START;
        end

        if (n_st.held_order == CMD_STOP) begin
            n_st.start_relay = 1'b0;
            n_st.power_relay = 1'b0;
            n_st.start_phase = SP_POWER_ON;
            n_st.start_count = '0;
        end
        if (n_st.held_order == CMD_START) begin
            throttle = 1'b1;
            unique case (i_state.start_phase)
                SP_POWER_ON: begin
                    n_st.start_relay = 1'b0;
                    n_st.power_relay = 1'b1;
                    n_st.start_phase = SP_POWER_WT;
                end
                SP_POWER_WT: begin
                    if (start_inc > {1'b0, i_cfg.power_wait_ticks}) begin
                        n_st.start_count = '0;
                        n_st.start_phase = SP_CRANK;
                    end else begin
                        n_st.start_count = start_inc[COUNT_W-1:0];
                    end
                end
                SP_CRANK: begin
                    n_st.power_relay = 1'b1;
                    n_st.start_relay = 1'b1;
                    n_st.start_phase = SP_CRANK_WT;
                end
                SP_CRANK_WT: begin
                    if (start_inc > {1'b0, i_cfg.crank_ticks}) begin
                        n_st.start_count = '0;
                        n_st.start_phase = SP_RELEASE;
                    end else begin
                        n_st.start_count = start_inc[COUNT_W-1:0];
                    end
                end
                SP_RELEASE: begin
                    n_st.start_relay = 1'b0;
                    n_st.power_relay = 1'b1;
                    n_st.held_order  = CMD_NONE;
                    n_st.start_phase = SP_POWER_ON;
                    n_st.start_count = '0;
                end
                default: begin
                end
            endcase
        end

        if (n_st.held_order == CMD_START) begin
            n_st.stop_phase = TP_OFF;
            n_st.stop_count = '0;
        end
        if (n_st.held_order == CMD_STOP) begin
            throttle = 1'b1;
            unique case (i_state.stop_phase)
                TP_OFF: begin
                    n_st.start_relay = 1'b0;
                    n_st.power_relay = 1'b0;
                    forced           = 1'b1;
                    n_st.stop_phase  = TP_WAIT;
                end
                TP_WAIT: begin
                    if (stop_inc > {1'b0, i_cfg.stop_wait_ticks}) begin
                        n_st.stop_count = '0;
                        n_st.stop_phase = TP_CLEAR;
                    end else begin
                        n_st.stop_count = stop_inc[COUNT_W-1:0];
                    end
                end
                TP_CLEAR: begin
                    n_st.start_relay = 1'b0;
                    n_st.power_relay = 1'b0;
                    n_st.held_order  = CMD_NONE;
                    forced           = 1'b1;
                    n_st.stop_phase  = TP_OFF;
                    n_st.stop_count  = '0;
                end
                default: begin
                end
            endcase
        end

        eff_speed    = forced ? '0 : i_item.speed_rpm;
        n_st.running = (eff_speed >= i_cfg.run_speed);
    end

    assign o_state                    = n_st;
    assign o_result.start_relay       = n_st.start_relay;
    assign o_result.power_relay       = n_st.power_relay;
    assign o_result.throttle_zero     = throttle;
    assign o_result.speed_forced_zero = forced;
    assign o_result.engine_running    = n_st.running;
    assign o_result.held_order        = n_st.held_order;

endmodule

// File: rtl/engine_start_stop_sequencer.sv
// ----------------------------------------------------------------------------
// engine_start_stop_sequencer
// Relay sequencer for engine start and stop, one control tick per transfer.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   t_in  (tick inputs)
//   out       output     o_out_valid / i_out_ready t_out (relay drives, order)
//   cfg       input      i_cfg_we                  index + 12-bit value
//
// One tick per cycle sustained while results are taken; a tick passes from the input
// transfer through the input register, then the tick logic into the result register.
// Synchronous active-low reset clears sequencer state and loads register
// defaults. A stalled result holds the result register and, once the input
// register is full, the input side; state advances only as a tick moves on.
// ----------------------------------------------------------------------------
module engine_start_stop_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ess_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ess_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ess_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ess_pkg::CFG_W-1:0]     i_cfg_data
);
    import ess_pkg::*;

    t_cfg   cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_out   r_out;
    logic   r_out_valid;
    t_state r_state;
    t_state n_state;
    t_out   n_out;
    logic   out_adv;
    logic   tick_go;

    ess_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ess_tick u_tick (
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_adv    = !r_out_valid || i_out_ready;
    assign tick_go    = r_in_valid && out_adv;
    assign o_in_ready = !r_in_valid || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.command     <= CMD_NONE;
            r_state.held_order  <= CMD_NONE;
            r_state.start_phase <= SP_POWER_ON;
            r_state.start_count <= '0;
            r_state.stop_phase  <= TP_OFF;
            r_state.stop_count  <= '0;
            r_state.running     <= 1'b0;
            r_state.start_relay <= 1'b0;
            r_state.power_relay <= 1'b0;
        end else if (tick_go) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_starter_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.start_relay |-> r_state.power_relay)
        else $error("starter relay closed without power relay");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_order != 2'd3)
        else $error("held order holds an unused code");

    a_forced_relays_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.speed_forced_zero)
            |-> (!r_out.start_relay && !r_out.power_relay && r_out.throttle_zero))
        else $error("forced speed with a relay closed");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_go |=> $stable(r_state))
        else $error("sequencer state moved without a tick");

endmodule

// File: sim/engine_start_stop_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// engine_start_stop_sequencer_test
// Self-checking bench for the engine start/stop relay sequencer. A short table
// of ticks covers field extremes, every control mode, halt, command code three
// and start while running; random ticks then run under several register
// settings, down to all zeros and up to waits at their ceiling. A behavioural
// copy of the sequencer predicts each result that the table does not give; every
// result is compared field by field as it leaves. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module engine_start_stop_sequencer_test;
    import ess_pkg::*;

    localparam int unsigned GAP_MAX          = 14;
    localparam int unsigned STALL_LIMIT      = 1000;
    localparam int unsigned LONG_START_TICKS = 40;
    localparam int unsigned LONG_STOP_TICKS  = 40;
    localparam int unsigned N_DIRECTED       = 16;
    localparam logic [1:0]  CMD_UNUSED       = 2'd3;

    typedef struct packed {
        logic typed;
        t_out value;
    } t_note;

    typedef struct packed {
        t_in  din;
        logic typed;
        t_out value;
    } t_row;

    // halt, mode, remote, upper, speed | typed | sr pr tz sf run, order
    localparam t_row DIRECTED [N_DIRECTED] = '{
        {1'b0, MODE_REMOTE, CMD_NONE,   CMD_NONE,   12'd0,    1'b1, 5'b00000, CMD_NONE},
        {1'b0, MODE_REMOTE, CMD_NONE,   CMD_NONE,   12'd4095, 1'b1, 5'b00001, CMD_NONE},
        {1'b0, MODE_REMOTE, CMD_START,  CMD_NONE,   12'd4095, 1'b1, 5'b00001, CMD_NONE},
        {1'b0, MODE_REMOTE, CMD_STOP,   CMD_NONE,   12'd4095, 1'b1, 5'b00110, CMD_STOP},
        {1'b0, MODE_KEEP,   CMD_NONE,   CMD_NONE,   12'd0,    1'b1, 5'b00100, CMD_STOP},
        {1'b1, MODE_KEEP,   CMD_START,  CMD_START,  12'd4095, 1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_MANUAL, CMD_START,  CMD_START,  12'd0,    1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_UPPER,  CMD_NONE,   CMD_START,  12'd499,  1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_REMOTE, CMD_UNUSED, CMD_STOP,   12'd500,  1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_KEEP,   CMD_STOP,   CMD_STOP,   12'd4095, 1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_UPPER,  CMD_NONE,   CMD_UNUSED, 12'd0,    1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_UPPER,  CMD_NONE,   CMD_STOP,   12'd0,    1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_MANUAL, CMD_NONE,   CMD_NONE,   12'd4095, 1'b0, 5'b00000, CMD_NONE},
        {1'b1, MODE_REMOTE, CMD_STOP,   CMD_STOP,   12'd0,    1'b0, 5'b00000, CMD_NONE},
        {1'b0, MODE_REMOTE, CMD_START,  CMD_NONE,   12'd0,    1'b0, 5'b00000, CMD_NONE},
        {1'b1, MODE_KEEP,   CMD_UNUSED, CMD_UNUSED, 12'd4095, 1'b0, 5'b00000, CMD_NONE}
    };

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in                   i_in_data  = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;

    // predictor state and register copy
    logic [1:0]            cmd_m;
    logic [1:0]            order_m;
    t_start_phase          sphase_m;
    t_stop_phase           tphase_m;
    logic [COUNT_W-1:0]    scount_m;
    logic [COUNT_W-1:0]    tcount_m;
    logic                  running_m;
    logic                  srelay_m;
    logic                  prelay_m;
    t_cfg                  cfg_m;

    t_note                 pending_notes[$];
    t_out                  relay_exp_q[$];
    int unsigned           mismatches   = 0;
    int unsigned           results_seen = 0;
    int unsigned           idle_cycles  = 0;
    int unsigned           ticks_sent   = 0;
    logic                  in_quiet     = 1'b0;
    logic                  out_quiet    = 1'b0;

    engine_start_stop_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic wait_done(inout logic [COUNT_W-1:0] count,
                                       input logic [CFG_W-1:0] limit);
        logic [COUNT_W:0] next;
        next = {1'b0, count} + 1'b1;
        if (next > {1'b0, limit}) begin
            count = '0;
            return 1'b1;
        end
        count = next[COUNT_W-1:0];
        return 1'b0;
    endfunction

    function automatic t_out predict_relays(input t_in d);
        t_out r;
        logic throttle;
        logic forced;
        throttle = 1'b0;
        forced   = 1'b0;
        if (d.halt) begin
            cmd_m = CMD_NONE;
        end else begin
            case (d.control_mode)
                MODE_REMOTE: cmd_m = d.remote_cmd;
                MODE_UPPER:  cmd_m = d.upper_cmd;
                MODE_MANUAL: cmd_m = CMD_NONE;
                default: ;
            endcase
        end
        if (cmd_m == CMD_STOP) begin
            order_m = CMD_STOP;
        end else if (cmd_m == CMD_START && !running_m) begin
            order_m = CMD_START;
        end

        if (order_m == CMD_STOP) begin
            srelay_m = 1'b0;
            prelay_m = 1'b0;
            sphase_m = SP_POWER_ON;
            scount_m = '0;
        end
        if (order_m == CMD_START) begin
            throttle = 1'b1;
            case (sphase_m)
                SP_POWER_ON: begin
                    srelay_m = 1'b0;
                    prelay_m = 1'b1;
                    sphase_m = SP_POWER_WT;
                end
                SP_POWER_WT: if (wait_done(scount_m, cfg_m.power_wait_ticks)) sphase_m = SP_CRANK;
                SP_CRANK: begin
                    prelay_m = 1'b1;
                    srelay_m = 1'b1;
                    sphase_m = SP_CRANK_WT;
                end
                SP_CRANK_WT: if (wait_done(scount_m, cfg_m.crank_ticks)) sphase_m = SP_RELEASE;
                SP_RELEASE: begin
                    srelay_m = 1'b0;
                    prelay_m = 1'b1;
                    order_m  = CMD_NONE;
                    sphase_m = SP_POWER_ON;
                    scount_m = '0;
                end
                default: ;
            endcase
        end

        if (order_m == CMD_START) begin
            tphase_m = TP_OFF;
            tcount_m = '0;
        end
        if (order_m == CMD_STOP) begin
            throttle = 1'b1;
            case (tphase_m)
                TP_OFF: begin
                    srelay_m = 1'b0;
                    prelay_m = 1'b0;
                    forced   = 1'b1;
                    tphase_m = TP_WAIT;
                end
                TP_WAIT: if (wait_done(tcount_m, cfg_m.stop_wait_ticks)) tphase_m = TP_CLEAR;
                TP_CLEAR: begin
                    srelay_m = 1'b0;
                    prelay_m = 1'b0;
                    order_m  = CMD_NONE;
                    forced   = 1'b1;
                    tphase_m = TP_OFF;
                    tcount_m = '0;
                end
                default: ;
            endcase
        end

        running_m = forced ? (cfg_m.run_speed == '0) : (d.speed_rpm >= cfg_m.run_speed);
        r.start_relay       = srelay_m;
        r.power_relay       = prelay_m;
        r.throttle_zero     = throttle;
        r.speed_forced_zero = forced;
        r.engine_running    = running_m;
        r.held_order        = order_m;
        return r;
    endfunction

    function automatic logic [1:0] random_cmd();
        int unsigned pick;
        pick = $urandom_range(0, 31);
        if (pick < 20) return CMD_NONE;
        if (pick < 25) return CMD_STOP;
        if (pick < 30) return CMD_START;
        return CMD_UNUSED;
    endfunction

    function automatic t_in random_tick();
        t_in         d;
        int unsigned pick;
        int          near;
        d.halt = ($urandom_range(0, 19) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 40)      d.control_mode = MODE_KEEP;
        else if (pick < 65) d.control_mode = MODE_REMOTE;
        else if (pick < 90) d.control_mode = MODE_UPPER;
        else                d.control_mode = MODE_MANUAL;
        d.remote_cmd = random_cmd();
        d.upper_cmd  = random_cmd();
        case ($urandom_range(0, 2))
            0: begin
                near = int'(cfg_m.run_speed) + int'($urandom_range(0, 4)) - 2;
                if (near < 0) near = 0;
                if (near > 4095) near = 4095;
                d.speed_rpm = 12'(near);
            end
            1: begin
                d.speed_rpm = (cfg_m.run_speed == '0) ? '0
                            : 12'($urandom_range(0, int'(cfg_m.run_speed) - 1));
            end
            default: d.speed_rpm = 12'($urandom_range(0, 4095));
        endcase
        return d;
    endfunction

    // order already held: the command path only keeps or clears
    function automatic t_in hold_tick();
        t_in d;
        d.halt         = 1'($urandom_range(0, 1));
        d.control_mode = ($urandom_range(0, 1) != 0) ? MODE_KEEP : MODE_MANUAL;
        d.remote_cmd   = 2'($urandom_range(0, 3));
        d.upper_cmd    = 2'($urandom_range(0, 3));
        d.speed_rpm    = 12'($urandom_range(0, 4094));
        return d;
    endfunction

    task automatic send_tick(input t_in d, input logic typed, input t_out value);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_notes.push_back({typed, value});
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        ticks_sent++;
        if (ticks_sent % 64 == 0) in_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_notes.size() != 0 || relay_exp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RUN_SPEED;
        i_cfg_data <= c.run_speed;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_POWER_WAIT;
        i_cfg_data <= c.power_wait_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CRANK;
        i_cfg_data <= c.crank_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STOP_WAIT;
        i_cfg_data <= c.stop_wait_ticks;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_m = c;
    endtask

    task automatic run_random(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 149) == 0) settle();
            send_tick(random_tick(), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_out  want;
        t_note note;
        logic  moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                want = predict_relays(i_in_data);
                note = pending_notes.pop_front();
                if (note.typed) want = note.value;
                relay_exp_q.push_back(want);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                results_seen++;
                if (relay_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: nothing outstanding, got %b", results_seen,
                                 o_out_data);
                end else begin
                    want = relay_exp_q.pop_front();
                    if (o_out_data.start_relay       !== want.start_relay
                     || o_out_data.power_relay       !== want.power_relay
                     || o_out_data.throttle_zero     !== want.throttle_zero
                     || o_out_data.speed_forced_zero !== want.speed_forced_zero
                     || o_out_data.engine_running    !== want.engine_running
                     || o_out_data.held_order        !== want.held_order) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected sr=%b pr=%b tz=%b sf=%b run=%b ",
                                      "ord=%0d, got sr=%b pr=%b tz=%b sf=%b run=%b ord=%0d"},
                                     results_seen, want.start_relay, want.power_relay,
                                     want.throttle_zero, want.speed_forced_zero,
                                     want.engine_running, want.held_order,
                                     o_out_data.start_relay, o_out_data.power_relay,
                                     o_out_data.throttle_zero, o_out_data.speed_forced_zero,
                                     o_out_data.engine_running, o_out_data.held_order);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[engine_start_stop_sequencer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            taken++;
            if (taken % 64 == 0) out_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        t_cfg c;
        t_row row;
        cmd_m     = CMD_NONE;
        order_m   = CMD_NONE;
        sphase_m  = SP_POWER_ON;
        tphase_m  = TP_OFF;
        scount_m  = '0;
        tcount_m  = '0;
        running_m = 1'b0;
        srelay_m  = 1'b0;
        prelay_m  = 1'b0;
        cfg_m     = {RST_RUN_SPEED, RST_POWER_WAIT, RST_CRANK, RST_STOP_WAIT};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int unsigned k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            send_tick(row.din, row.typed, row.value);
        end

        load_config({12'd0, 12'd0, 12'd0, 12'd0});
        run_random(150);

        repeat (6) begin
            c.run_speed        = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                             : 12'($urandom_range(200, 2500));
            c.power_wait_ticks = 12'($urandom_range(0, 6));
            c.crank_ticks      = 12'($urandom_range(0, 6));
            c.stop_wait_ticks  = 12'($urandom_range(0, 6));
            load_config(c);
            run_random(230);
        end

        // waits at their ceiling: run part way into a start and a stop
        load_config({12'd4095, 12'd4095, 12'd4095, 12'd4095});
        send_tick({1'b0, MODE_REMOTE, CMD_START, CMD_NONE, 12'd0}, 1'b0, '0);
        repeat (LONG_START_TICKS) send_tick(hold_tick(), 1'b0, '0);
        send_tick({1'b0, MODE_REMOTE, CMD_STOP, CMD_NONE, 12'd0}, 1'b0, '0);
        repeat (LONG_STOP_TICKS) send_tick(hold_tick(), 1'b0, '0);

        load_config({RST_RUN_SPEED, RST_POWER_WAIT, RST_CRANK, RST_STOP_WAIT});
        run_random(150);

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[engine_start_stop_sequencer] OK");
        end else begin
            $display("[engine_start_stop_sequencer] ERROR");
        end
        $finish;
    end

endmodule

// File: engine_start_stop_sequencer.f
rtl/ess_pkg.sv
rtl/ess_cfg_regs.sv
rtl/ess_tick.sv
rtl/engine_start_stop_sequencer.sv
sim/engine_start_stop_sequencer_test.sv
